FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// immediate implication checked on every clock edge out of reset
`define JSU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
    localparam logic [2:0] ERR_CONTROL   = 3'd2;
    localparam logic [2:0] ERR_ESCAPE    = 3'd3;
    localparam logic [2:0] ERR_HEX       = 3'd4;
    localparam logic [2:0] ERR_SURROGATE = 3'd5;

    // results caused by one accepted beat
    typedef struct packed {
        logic [2:0]             n;
        logic [1:0]             kind;
        logic [2:0]             err;
        logic [3:0][7:0]        bytes;
        logic [LENGTH_BITS-1:0] base;
    } jsu_job_t;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] bytes;
    } jsu_utf8_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic jsu_utf8_t utf8_enc(input logic [20:0] cp);
        jsu_utf8_t r;
        r = '0;
        if (cp <= 21'h7F) begin
            r.n        = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            r.n        = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            r.n        = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.n        = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    // saturating add of a small count
    function automatic logic [LENGTH_BITS-1:0] len_add(input logic [LENGTH_BITS-1:0] len,
                                                       input logic [2:0] n);
        logic [LENGTH_BITS:0] s;
        s = {1'b0, len} + {{(LENGTH_BITS-2){1'b0}}, n};
        return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
    endfunction

    // clamp to the 16-bit result field
    function automatic logic [15:0] len_out(input logic [LENGTH_BITS-1:0] len);
        logic [LENGTH_BITS+15:0] w;
        w = {16'd0, len};
        return (w > (LENGTH_BITS+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/jsu_front.sv
`default_nettype none

module jsu_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic             q_full,
    input  wire logic [1:0]       in_cmd,
    input  wire logic [7:0]       in_byte,
    output logic                  in_ready,
    output logic                  q_push,
    output jsu_pkg::jsu_job_t     q_job
);
    import jsu_pkg::*;

    localparam logic [3:0] MODE_IDLE  = 4'd0;
    localparam logic [3:0] MODE_TEXT  = 4'd1;
    localparam logic [3:0] MODE_ESC   = 4'd2;
    localparam logic [3:0] MODE_HIHEX = 4'd3;
    localparam logic [3:0] MODE_SURBS = 4'd4;
    localparam logic [3:0] MODE_SURU  = 4'd5;
    localparam logic [3:0] MODE_LOHEX = 4'd6;
    localparam logic [3:0] MODE_HOLD  = 4'd7;

    logic [3:0]             mode_reg, mode_next;
    logic [15:0]            hex_reg, hex_next;
    logic [2:0]             digits_reg, digits_next;
    logic [9:0]             hi_reg, hi_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;

    logic       accept;
    logic [4:0] hv;
    logic [15:0] new_hex;
    logic [2:0] nd;
    logic [20:0] cp;
    jsu_utf8_t  enc;
    jsu_job_t   job;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign hv       = hex_val(in_byte);
    assign new_hex  = {hex_reg[11:0], hv[3:0]};
    assign nd       = digits_reg + 3'd1;
    // low escape combines with the stored high half into a supplementary code point
    assign cp       = (mode_reg == MODE_LOHEX)
                      ? (21'h10000 + {1'b0, hi_reg, new_hex[9:0]})
                      : {5'd0, new_hex};
    assign enc      = utf8_enc(cp);

    always_comb begin
        mode_next   = mode_reg;
        hex_next    = hex_reg;
        digits_next = digits_reg;
        hi_next     = hi_reg;
        len_next    = len_reg;
        job         = '0;
        job.base    = len_reg;

        if (accept) begin
            unique case (in_cmd)
                CMD_BEGIN: begin
                    mode_next   = MODE_TEXT;
                    hex_next    = '0;
                    digits_next = '0;
                    hi_next     = '0;
                end
                CMD_BYTE: begin
                    unique case (mode_reg)
                        MODE_TEXT: begin
                            if (in_byte == 8'h22) begin
                                job.n     = 3'd1;
                                job.kind  = KIND_DONE;
                                mode_next = MODE_IDLE;
                            end else if (in_byte == 8'h5C) begin
                                mode_next = MODE_ESC;
                            end else if (in_byte < 8'h20) begin
                                job.n     = 3'd1;
                                job.kind  = KIND_ERROR;
                                job.err   = ERR_CONTROL;
                                mode_next = MODE_IDLE;
                            end else begin
                                job.n        = 3'd1;
                                job.bytes[0] = in_byte;
                            end
                        end
                        MODE_ESC: begin
                            mode_next = MODE_TEXT;
                            job.n     = 3'd1;
                            unique case (in_byte)
                                8'h5C, 8'h22, 8'h2F: job.bytes[0] = in_byte;
                                8'h62: job.bytes[0] = 8'h08;
                                8'h66: job.bytes[0] = 8'h0C;
                                8'h6E: job.bytes[0] = 8'h0A;
                                8'h72: job.bytes[0] = 8'h0D;
                                8'h74: job.bytes[0] = 8'h09;
                                8'h75: begin
                                    job.n       = 3'd0;
                                    mode_next   = MODE_HIHEX;
                                    hex_next    = '0;
                                    digits_next = '0;
                                end
                                default: begin
                                    job.kind  = KIND_ERROR;
                                    job.err   = ERR_ESCAPE;
                                    mode_next = MODE_IDLE;
                                end
                            endcase
                        end
                        MODE_HIHEX: begin
                            if (!hv[4]) begin
                                job.n     = 3'd1;
                                job.kind  = KIND_ERROR;
                                job.err   = ERR_HEX;
                                mode_next = MODE_IDLE;
                            end else begin
                                hex_next    = new_hex;
                                digits_next = nd;
                                if (nd == 3'd4) begin
                                    digits_next = '0;
                                    if (new_hex >= 16'hD800 && new_hex <= 16'hDBFF) begin
                                        hi_next   = new_hex[9:0];
                                        mode_next = MODE_SURBS;
                                    end else if (new_hex >= 16'hDC00 && new_hex <= 16'hDFFF) begin
                                        job.n     = 3'd1;
                                        job.kind  = KIND_ERROR;
                                        job.err   = ERR_SURROGATE;
                                        mode_next = MODE_IDLE;
                                    end else begin
                                        job.n     = enc.n;
                                        job.bytes = enc.bytes;
                                        mode_next = MODE_TEXT;
                                    end
                                end
                            end
                        end
                        MODE_SURBS, MODE_SURU: begin
                            if (mode_reg == MODE_SURBS && in_byte == 8'h5C) begin
                                mode_next = MODE_SURU;
                            end else if (mode_reg == MODE_SURU && in_byte == 8'h75) begin
                                mode_next   = MODE_LOHEX;
                                hex_next    = '0;
                                digits_next = '0;
                            end else begin
                                job.n     = 3'd1;
                                job.kind  = KIND_ERROR;
                                job.err   = ERR_SURROGATE;
                                mode_next = MODE_IDLE;
                            end
                        end
                        MODE_LOHEX: begin
                            digits_next = nd;
                            if (!hv[4]) begin
                                // a bad digit is held until the fourth digit position
                                if (nd >= 3'd4) begin
                                    job.n     = 3'd1;
                                    job.kind  = KIND_ERROR;
                                    job.err   = ERR_HEX;
                                    mode_next = MODE_IDLE;
                                end else begin
                                    mode_next = MODE_HOLD;
                                end
                            end else begin
                                hex_next = new_hex;
                                if (nd >= 3'd4) begin
                                    digits_next = '0;
                                    if (new_hex < 16'hDC00 || new_hex > 16'hDFFF) begin
                                        job.n     = 3'd1;
                                        job.kind  = KIND_ERROR;
                                        job.err   = ERR_SURROGATE;
                                        mode_next = MODE_IDLE;
                                    end else begin
                                        job.n     = enc.n;
                                        job.bytes = enc.bytes;
                                        mode_next = MODE_TEXT;
                                    end
                                end
                            end
                        end
                        MODE_HOLD: begin
                            digits_next = nd;
                            if (nd >= 3'd4) begin
                                job.n     = 3'd1;
                                job.kind  = KIND_ERROR;
                                job.err   = ERR_HEX;
                                mode_next = MODE_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_END: begin
                    job.n    = 3'd1;
                    job.kind = KIND_ERROR;
                    unique case (mode_reg)
                        MODE_TEXT:  job.err = ERR_NO_QUOTE;
                        MODE_ESC:   job.err = ERR_ESCAPE;
                        MODE_HIHEX: job.err = (digits_reg == 3'd0) ? ERR_ESCAPE : ERR_HEX;
                        MODE_SURBS, MODE_SURU, MODE_LOHEX, MODE_HOLD: job.err = ERR_SURROGATE;
                        default: job.n = 3'd0;
                    endcase
                    mode_next = MODE_IDLE;
                end
                default: ;
            endcase

            if (in_cmd == CMD_BEGIN) begin
                len_next = '0;
            end else if (job.kind == KIND_DATA) begin
                len_next = len_add(len_reg, job.n);
            end
            if (mode_next == MODE_IDLE) begin
                digits_next = '0;
            end
        end
    end

    assign q_push = accept && (job.n != 3'd0);
    assign q_job  = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            hex_reg    <= '0;
            digits_reg <= '0;
            hi_reg     <= '0;
            len_reg    <= '0;
        end else begin
            mode_reg   <= mode_next;
            hex_reg    <= hex_next;
            digits_reg <= digits_next;
            hi_reg     <= hi_next;
            len_reg    <= len_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_queue.sv
`default_nettype none

module jsu_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire jsu_pkg::jsu_job_t push_job,
    input  wire logic              pop,
    output logic                   full,
    output logic                   empty,
    output jsu_pkg::jsu_job_t      head_job
);
    import jsu_pkg::*;

    jsu_job_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_back.sv
`default_nettype none

module jsu_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_empty,
    input  wire jsu_pkg::jsu_job_t q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             out_kind,
    output logic [7:0]             out_byte,
    output logic [2:0]             out_err,
    output logic [15:0]            out_len,
    output logic                   out_last
);
    import jsu_pkg::*;

    logic        valid_reg, valid_next;
    logic [1:0]  idx_reg, idx_next;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [2:0]  err_reg;
    logic [15:0] len_reg;
    logic        last_reg;

    logic        load;
    logic        is_last;
    logic [2:0]  idx_plus;

    assign load     = !q_empty && (!valid_reg || out_ready);
    assign idx_plus = {1'b0, idx_reg} + 3'd1;
    assign is_last  = (idx_plus == q_head.n);
    assign q_pop    = load && is_last;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= q_head.kind;
            byte_reg <= q_head.bytes[idx_reg];
            err_reg  <= q_head.err;
            last_reg <= is_last;
            // data beats count themselves, completion and errors report the running total
            len_reg  <= (q_head.kind == KIND_DATA) ? len_out(len_add(q_head.base, idx_plus))
                                                   : len_out(q_head.base);
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_err   = err_reg;
    assign out_len   = len_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/json_string_unescape_utf8.sv
// JSON string body decoder, unescaping to UTF-8.
// Input stream: s_tuser carries the command (begin string after the opening
// quote, text byte, end of text), s_tdata the raw text byte. One beat may be
// accepted every cycle; s_tready drops only when the four-entry queue between
// the decoder and the output sequencer is full.
// Output stream: one beat per result. m_tuser is the kind (data byte, string
// complete, error), m_tdata packs the decoded byte, error code and the
// saturating decoded length; m_tlast marks the final result of an input beat.
// Path: the decoder is combinational; each result is written into the queue, then
// loaded into the output register. Throughput: one input beat and one output beat
// per cycle while the queue is not full and m_tready is high; a \u escape that decodes
// to 2..4 UTF-8 bytes takes one output beat per byte, paid for by its escape characters.
// Reset (aresetn low, synchronous) closes any open string and empties the
// queue and output register. When m_tready is low the output beat holds, the
// queue fills, and s_tready falls once it is full.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] out_byte, [10:8] error_code, [26:11] string_length
    output logic [1:0]       m_tuser,   // [1:0] out_kind
    output logic             m_tlast    // last_of_run
);
    import jsu_pkg::*;

    logic     q_push, q_pop, q_full, q_empty;
    jsu_job_t q_job, q_head;
    logic [7:0]  out_byte;
    logic [2:0]  out_err;
    logic [15:0] out_len;

    jsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .q_full   (q_full),
        .in_cmd   (s_tuser),
        .in_byte  (s_tdata),
        .in_ready (s_tready),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    jsu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_job (q_head)
    );

    jsu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_byte  (out_byte),
        .out_err   (out_err),
        .out_len   (out_len),
        .out_last  (m_tlast)
    );

    assign m_tdata = {5'd0, out_len, out_err, out_byte};

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_checker.sv
`default_nettype none
`include "assert_macros.svh"

module jsu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    import jsu_pkg::*;

    // a stalled beat keeps its payload
    `JSU_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output beat changed while stalled")

    // completion and errors are single results with a zero byte
    `JSU_ASSERT_SAME(a_single, m_tvalid && m_tuser != KIND_DATA, m_tlast && m_tdata[7:0] == 8'd0, "status beat not last or has a byte")

    // errors carry a known code, other beats none
    `JSU_ASSERT_SAME(a_err, m_tvalid, (m_tuser == KIND_ERROR) == (m_tdata[10:8] >= ERR_NO_QUOTE && m_tdata[10:8] <= ERR_SURROGATE), "error code does not match kind")

    // a data beat always counts at least itself
    `JSU_ASSERT_SAME(a_len, m_tvalid && m_tuser == KIND_DATA, m_tdata[26:11] != 16'd0, "data beat with zero length")

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
